/* design/kecf_pkg.sv */
// kecf_pkg: shared constants, entry layout, controller/datapath command and status types
// and fingerprint helpers for the key entry cache
// no dependencies
`timescale 1ns / 1ps

package kecf_pkg;

	localparam int ENTRIES  = 16;
	localparam int FP_BYTES = 27;
	localparam int FP_MAX   = 32;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int FP_W     = FP_BYTES * 8;
	localparam int FP_IN_W  = 216;
	localparam int LEN_W    = 12;
	localparam int EPOCH_W  = 32;
	localparam int KEY_W    = 64;
	localparam int OP_W     = 2;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [LEN_W-1:0]   len;
		logic [FP_W-1:0]    fp;
		logic [KEY_W-1:0]   odd_lo;
		logic [KEY_W-1:0]   odd_hi;
		logic [KEY_W-1:0]   even_lo;
		logic [KEY_W-1:0]   even_hi;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic lookup_start;
		logic store;
		logic clear;
		logic scan_issue;
		logic hit_set;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic match;
		logic scan_end;
		logic iss_done;
		logic out_free;
	} sts_t;

	// byte 0 lands in the top byte; bytes past the input are zero
	function automatic logic [FP_W-1:0] fp_pack(input logic [63:0] w0, input logic [63:0] w1,
			input logic [63:0] w2, input logic [23:0] w3);
		logic [FP_MAX*8-1:0] full;
		full = {w0, w1, w2, w3, {(FP_MAX*8-FP_IN_W){1'b0}}};
		return full[FP_MAX*8-1 -: FP_W];
	endfunction

	// ones over the first min(len, FP_BYTES) bytes
	function automatic logic [FP_W-1:0] fp_mask(input logic [LEN_W-1:0] len);
		logic [FP_W-1:0] m;
		m = '0;
		for (int i = 0; i < FP_BYTES; i++) begin
			if (int'(len) > i) m[FP_W-1-8*i -: 8] = 8'hFF;
		end
		return m;
	endfunction

endpackage

/* design/kecf_ram.sv */
// kecf_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module kecf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

/* design/kecf_ctrl.sv */
// kecf_ctrl: sequencing state machine for the key entry cache
// depends on kecf_pkg
`timescale 1ns / 1ps

module kecf_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [kecf_pkg::OP_W-1:0] op,
	input  kecf_pkg::sts_t            sts,
	output kecf_pkg::cmd_t            cmd
);
	import kecf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_stall  = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (op == OP_LOOKUP) begin
						cmd.lookup_start = 1'b1;
						state_nxt        = ST_SCAN;
					end else begin
						cmd.store = (op == OP_STORE);
						cmd.clear = (op == OP_CLEAR);
						state_nxt = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (sts.match) begin
					cmd.hit_set = 1'b1;
					state_nxt   = ST_DONE;
				end else if (sts.scan_end) begin
					state_nxt = ST_DONE;
				end else if (!sts.iss_done) begin
					cmd.scan_issue = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nxt;
	end

endmodule

/* design/kecf_dp.sv */
// kecf_dp: entry ram, valid bits, replacement pointer, scan compare and output register
// depends on kecf_pkg and kecf_ram
`timescale 1ns / 1ps

module kecf_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kecf_pkg::cmd_t               cmd,
	output kecf_pkg::sts_t               sts,
	input  logic [kecf_pkg::LEN_W-1:0]   msg_len,
	input  logic [kecf_pkg::EPOCH_W-1:0] epoch_in,
	input  logic [63:0]                  fp_word0,
	input  logic [63:0]                  fp_word1,
	input  logic [63:0]                  fp_word2,
	input  logic [23:0]                  fp_word3,
	input  logic [kecf_pkg::KEY_W-1:0]   odd_lo,
	input  logic [kecf_pkg::KEY_W-1:0]   odd_hi,
	input  logic [kecf_pkg::KEY_W-1:0]   even_lo,
	input  logic [kecf_pkg::KEY_W-1:0]   even_hi,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic [kecf_pkg::KEY_W-1:0]   odd_lo_out,
	output logic [kecf_pkg::KEY_W-1:0]   odd_hi_out,
	output logic [kecf_pkg::KEY_W-1:0]   even_lo_out,
	output logic [kecf_pkg::KEY_W-1:0]   even_hi_out
);
	import kecf_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] valid_nxt;
	logic [IDX_W-1:0]   slot_q;
	logic [IDX_W-1:0]   slot_eff;
	logic [EPOCH_W-1:0] epoch_seen_q;
	logic               flush;

	logic [LEN_W-1:0] len_q;
	logic [FP_W-1:0]  fp_q;
	logic [FP_W-1:0]  mask_q;
	logic [FP_W-1:0]  in_fp;
	logic [FP_W-1:0]  in_mask;
	logic [IDX_W-1:0] idx_q;
	logic             iss_done_q;
	logic             hit_q;

	logic   cmp_vld_s1;
	logic   cmp_last_s1;
	logic   v_s1;
	entry_t wr_entry;
	entry_t rd_entry;
	logic   match;
	logic   out_valid_q;

	assign in_fp   = fp_pack(fp_word0, fp_word1, fp_word2, fp_word3);
	assign in_mask = fp_mask(msg_len);

	// a store under a new epoch empties the cache first
	assign flush    = cmd.store && (epoch_seen_q != '0) && (epoch_in != epoch_seen_q);
	assign slot_eff = flush ? '0 : slot_q;

	always_comb begin
		wr_entry.epoch   = epoch_in;
		wr_entry.len     = msg_len;
		wr_entry.fp      = in_fp & in_mask;
		wr_entry.odd_lo  = odd_lo;
		wr_entry.odd_hi  = odd_hi;
		wr_entry.even_lo = even_lo;
		wr_entry.even_hi = even_hi;
	end

	always_comb begin
		valid_nxt = valid_q;
		if (cmd.clear || flush) valid_nxt = '0;
		if (cmd.store) valid_nxt[slot_eff] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			slot_q       <= '0;
			epoch_seen_q <= '0;
		end else begin
			valid_q <= valid_nxt;
			if (cmd.clear) slot_q <= '0;
			else if (cmd.store) begin
				slot_q       <= (slot_eff == IDX_W'(ENTRIES - 1)) ? '0 : slot_eff + 1'b1;
				epoch_seen_q <= epoch_in;
			end
		end
	end

	kecf_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(slot_eff),
		.wdata(wr_entry),
		.re   (cmd.scan_issue),
		.raddr(idx_q),
		.rdata(rd_entry)
	);

	// lookup operands
	always_ff @(posedge clk) begin
		if (cmd.lookup_start) begin
			len_q  <= msg_len;
			fp_q   <= in_fp;
			mask_q <= in_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			iss_done_q  <= 1'b0;
			hit_q       <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			if (cmd.accept) hit_q <= 1'b0;
			else if (cmd.hit_set) hit_q <= 1'b1;
			if (cmd.lookup_start) begin
				idx_q      <= '0;
				iss_done_q <= 1'b0;
			end else if (cmd.scan_issue) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == IDX_W'(ENTRIES - 1)) iss_done_q <= 1'b1;
			end
			cmp_vld_s1  <= cmd.scan_issue;
			cmp_last_s1 <= (idx_q == IDX_W'(ENTRIES - 1));
			v_s1        <= valid_q[idx_q];
		end
	end

	// entry compare in the cycle after the read is issued
	assign match = v_s1
		&& ((epoch_seen_q == '0) || (rd_entry.epoch == epoch_seen_q))
		&& (rd_entry.len == len_q)
		&& (((rd_entry.fp ^ fp_q) & mask_q) == '0);

	assign sts.match    = cmp_vld_s1 && match;
	assign sts.scan_end = cmp_vld_s1 && cmp_last_s1;
	assign sts.iss_done = iss_done_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			hit         <= hit_q;
			odd_lo_out  <= hit_q ? rd_entry.odd_lo : '0;
			odd_hi_out  <= hit_q ? rd_entry.odd_hi : '0;
			even_lo_out <= hit_q ? rd_entry.even_lo : '0;
			even_hi_out <= hit_q ? rd_entry.even_hi : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* design/key_entry_cache_fifo.sv */
// key_entry_cache_fifo: top level of the associative key pair cache with round-robin fill
// depends on kecf_pkg, kecf_ctrl, kecf_dp (which holds kecf_ram)
`timescale 1ns / 1ps

// associative cache of ENTRIES key pairs, each tagged with a fingerprint, a message length
// and an epoch. every accepted beat on the input gives exactly one beat on the output.
// a lookup (op 0) walks the entries in index order through the single read port of the
// entry ram, one entry per cycle, and stops at the first entry that is valid, has the same
// length, the same first min(length, FP_BYTES) fingerprint bytes and, unless the last stored
// epoch is zero, an epoch equal to it; a miss returns hit low and zero keys. the input is
// stalled from each accept until its result is loaded into the output register. a store
// (op 1) writes the next round-robin slot in the accept cycle, first emptying the cache
// when a nonzero stored epoch differs from epoch_in; store, clear (op 2) and the unused
// op 3 answer with hit low and zero keys. clear keeps the stored epoch. the result sits
// in an output register, so output stall only delays the next item once a second result
// is ready.

module key_entry_cache_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [kecf_pkg::OP_W-1:0]    op,
	input  logic [kecf_pkg::LEN_W-1:0]   msg_len,
	input  logic [kecf_pkg::EPOCH_W-1:0] epoch_in,
	input  logic [63:0]                  fp_word0,
	input  logic [63:0]                  fp_word1,
	input  logic [63:0]                  fp_word2,
	input  logic [23:0]                  fp_word3,
	input  logic [kecf_pkg::KEY_W-1:0]   odd_lo,
	input  logic [kecf_pkg::KEY_W-1:0]   odd_hi,
	input  logic [kecf_pkg::KEY_W-1:0]   even_lo,
	input  logic [kecf_pkg::KEY_W-1:0]   even_hi,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic [kecf_pkg::KEY_W-1:0]   odd_lo_out,
	output logic [kecf_pkg::KEY_W-1:0]   odd_hi_out,
	output logic [kecf_pkg::KEY_W-1:0]   even_lo_out,
	output logic [kecf_pkg::KEY_W-1:0]   even_hi_out
);
	import kecf_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: idle / scan / result hand-off
	kecf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op      (op),
		.sts     (sts),
		.cmd     (cmd)
	);

	// entry storage, compare and output register
	kecf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.msg_len    (msg_len),
		.epoch_in   (epoch_in),
		.fp_word0   (fp_word0),
		.fp_word1   (fp_word1),
		.fp_word2   (fp_word2),
		.fp_word3   (fp_word3),
		.odd_lo     (odd_lo),
		.odd_hi     (odd_hi),
		.even_lo    (even_lo),
		.even_hi    (even_hi),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.odd_lo_out (odd_lo_out),
		.odd_hi_out (odd_hi_out),
		.even_lo_out(even_lo_out),
		.even_hi_out(even_hi_out)
	);

	// a miss never carries key data
	a_miss_zero_keys: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (odd_lo_out == '0 && odd_hi_out == '0
			&& even_lo_out == '0 && even_hi_out == '0))
		else $error("miss beat with nonzero keys");

	// at most one kind of operation starts per beat
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.lookup_start, cmd.store, cmd.clear}))
		else $error("more than one operation started");

	// the scan never reads past the last entry
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_issue |-> !sts.iss_done)
		else $error("entry read issued after scan finished");

	// a new result is only loaded when the output register can take it
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a pending beat");

endmodule
